### rtl/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// Constants and helpers for the epoch seconds to civil date pipeline.
// ----------------------------------------------------------------------------
package ecd_pkg;

    localparam int EPOCH_W  = 41;
    localparam int OFFSET_W = 17;
    localparam int YEAR_W   = 17;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd3600;

    // 86400 * 2^24 minus the seconds from 1970-01-01 to 2000-03-01
    localparam logic [41:0] SECONDS_BIAS = 42'd1448599593600;
    // 2^24 days removed, 88 eras of 146097 days added
    localparam int DAY_BIAS  = 3920680;
    localparam int ERA_BIAS  = 88;
    localparam int YEAR_BASE = 2000 - 400 * ERA_BIAS;

    localparam int D_675   = 675;
    localparam int R_675_H = 388;
    localparam int R_675_L = 198841;
    localparam int D_400Y  = 146097;
    localparam int R_400Y  = 229;
    localparam int D_100Y  = 36524;
    localparam int D_4Y    = 1461;
    localparam int R_4Y    = 11483;
    localparam int D_1Y    = 365;
    localparam int D_HOUR  = 3600;
    localparam int R_HOUR  = 36;
    localparam int D_MIN   = 60;
    localparam int R_MIN   = 68;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    // first day of each month, counted from march
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] s;
        unique case (idx)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

### rtl/epoch_seconds_to_civil_date.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_date
// Signed epoch seconds plus local offset to proleptic Gregorian date and time.
// ----------------------------------------------------------------------------
// Fully pipelined through 18 register stages: one beat enters every cycle
// unless the output beat is not taken, which holds the whole pipeline. Each
// division by 675, 146097, 1461, 3600 or 60 is a reciprocal multiply, a
// multiply back and a one-step correction, each in its own register stage;
// the 100-year and 1-year steps use compares. The offset register is written
// directly and should be changed only while the pipeline is empty.
module epoch_seconds_to_civil_date
    import ecd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // epoch_seconds[40:0], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // year, month, day_of_month, hour, minute, second, zero
    output logic        m_axis_tuser    // out_of_range
);

    localparam int STAGES = 18;

    logic                en;
    logic [STAGES-1:0]   v_reg;
    logic [STAGES-1:0]   v_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic                oor_reg [1:STAGES];

    // stage 1
    logic [41:0] sum1;
    logic [40:0] t1_next;
    logic [40:0] t1_reg;
    // stage 2
    logic [41:0] ap2;
    logic [17:0] bh2_reg;
    logic [16:0] bl2_reg;
    logic [6:0]  lo2_reg;
    // stage 3
    logic [26:0] p3;
    logic [8:0]  q1e3_reg;
    logic [17:0] bh3_reg;
    logic [16:0] bl3_reg;
    logic [6:0]  lo3_reg;
    // stage 4
    logic [17:0] d4;
    logic [10:0] r1w4_reg;
    logic [8:0]  q1e4_reg;
    logic [16:0] bl4_reg;
    logic [6:0]  lo4_reg;
    // stage 5
    logic [9:0]  r1_5_reg;
    logic [8:0]  q1_5_reg;
    logic [16:0] bl5_reg;
    logic [6:0]  lo5_reg;
    // stage 6
    logic [26:0] x6;
    logic [44:0] p6;
    logic [26:0] x6_reg;
    logic [16:0] q2e6_reg;
    logic [8:0]  q1_6_reg;
    logic [6:0]  lo6_reg;
    // stage 7
    logic [26:0] d7;
    logic [10:0] r2w7_reg;
    logic [16:0] q2e7_reg;
    logic [8:0]  q1_7_reg;
    logic [6:0]  lo7_reg;
    // stage 8
    logic        ge8;
    logic [9:0]  r2_8;
    logic [16:0] q2_8;
    logic [25:0] days8_reg;
    logic [16:0] sod8_reg;
    // stage 9
    logic [25:0] dd9;
    logic [22:0] ph9;
    logic [24:0] dd9_reg;
    logic [4:0]  he9_reg;
    logic [16:0] sod9_reg;
    // stage 10
    logic [32:0] pc10;
    logic [16:0] dh10;
    logic [7:0]  qce10_reg;
    logic [24:0] dd10_reg;
    logic [12:0] hrw10_reg;
    logic [4:0]  he10_reg;
    // stage 11
    logic [24:0] dc11;
    logic        ge11;
    logic [18:0] rdw11_reg;
    logic [7:0]  qce11_reg;
    logic [4:0]  hour11_reg;
    logic [11:0] hrem11_reg;
    // stage 12
    logic        ge12;
    logic [17:0] pm12;
    logic [17:0] rd12_reg;
    logic [7:0]  qc12_reg;
    logic [5:0]  me12_reg;
    logic [11:0] hrem12_reg;
    logic [4:0]  hour12_reg;
    // stage 13
    logic [1:0]  c13;
    logic [17:0] cc13;
    logic [11:0] ds13;
    logic [1:0]  c13_reg;
    logic [15:0] rdc13_reg;
    logic [7:0]  qc13_reg;
    logic [6:0]  sw13_reg;
    logic [5:0]  me13_reg;
    logic [4:0]  hour13_reg;
    // stage 14
    logic [29:0] pq14;
    logic        ge14;
    logic [4:0]  qe14_reg;
    logic [15:0] rdc14_reg;
    logic [1:0]  c14_reg;
    logic [7:0]  qc14_reg;
    tod_t        tod14_reg;
    // stage 15
    logic [15:0] d15;
    logic [11:0] r4w15_reg;
    logic [4:0]  qe15_reg;
    logic [1:0]  c15_reg;
    logic [7:0]  qc15_reg;
    tod_t        tod15_reg;
    // stage 16
    logic        ge16;
    logic [4:0]  q16_reg;
    logic [10:0] r16_reg;
    logic [1:0]  c16_reg;
    logic [7:0]  qc16_reg;
    tod_t        tod16_reg;
    // stage 17
    logic [1:0]  y17;
    logic [10:0] yc17;
    logic [1:0]  y17_reg;
    logic [8:0]  ry17_reg;
    logic [4:0]  q17_reg;
    logic [1:0]  c17_reg;
    logic [7:0]  qc17_reg;
    tod_t        tod17_reg;
    // stage 18
    logic [3:0]        idx18;
    logic [8:0]        dm18;
    logic [17:0]       yr18;
    logic [YEAR_W-1:0] year_reg;
    logic [3:0]        month_reg;
    logic [4:0]        day_reg;
    tod_t              tod18_reg;

    assign en            = !v_reg[STAGES-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign v_next        = {v_reg[STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            offset_reg <= OFFSET_RESET;
        end
        else
        begin
            if (en)
            begin
                v_reg <= v_next;
            end
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        sum1 = {s_axis_tdata[40], s_axis_tdata[40:0]}
             + {{(42-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg};
        if (sum1[41] != sum1[40])
        begin
            t1_next = sum1[41] ? {1'b1, 40'd0} : {1'b0, {40{1'b1}}};
        end
        else
        begin
            t1_next = sum1[40:0];
        end
        ap2  = {t1_reg[40], t1_reg} + SECONDS_BIAS;
        p3   = 27'(bh2_reg) * 27'(R_675_H);
        d4   = bh3_reg - 18'(18'(q1e3_reg) * 18'(D_675));
        x6   = {r1_5_reg, bl5_reg};
        p6   = 45'(x6) * 45'(R_675_L);
        d7   = x6_reg - 27'(27'(q2e6_reg) * 27'(D_675));
        ge8  = r2w7_reg >= 11'(D_675);
        r2_8 = ge8 ? 10'(r2w7_reg - 11'(D_675)) : r2w7_reg[9:0];
        q2_8 = q2e7_reg + 17'(ge8);
        dd9  = days8_reg - 26'(DAY_BIAS);
        ph9  = 23'(sod8_reg) * 23'(R_HOUR);
        pc10 = 33'(dd9_reg) * 33'(R_400Y);
        dh10 = sod9_reg - 17'(17'(he9_reg) * 17'(D_HOUR));
        dc11 = dd10_reg - 25'(25'(qce10_reg) * 25'(D_400Y));
        ge11 = hrw10_reg >= 13'(D_HOUR);
        ge12 = rdw11_reg >= 19'(D_400Y);
        pm12 = 18'(hrem11_reg) * 18'(R_MIN);
        if (rd12_reg >= 18'(3 * D_100Y))
        begin
            c13 = 2'd3;
        end
        else if (rd12_reg >= 18'(2 * D_100Y))
        begin
            c13 = 2'd2;
        end
        else if (rd12_reg >= 18'(D_100Y))
        begin
            c13 = 2'd1;
        end
        else
        begin
            c13 = 2'd0;
        end
        cc13 = 18'(18'(c13) * 18'(D_100Y));
        ds13 = hrem12_reg - 12'(12'(me12_reg) * 12'(D_MIN));
        pq14 = 30'(rdc13_reg) * 30'(R_4Y);
        ge14 = sw13_reg >= 7'(D_MIN);
        d15  = rdc14_reg - 16'(16'(qe14_reg) * 16'(D_4Y));
        ge16 = r4w15_reg >= 12'(D_4Y);
        if (r16_reg >= 11'(3 * D_1Y))
        begin
            y17 = 2'd3;
        end
        else if (r16_reg >= 11'(2 * D_1Y))
        begin
            y17 = 2'd2;
        end
        else if (r16_reg >= 11'(D_1Y))
        begin
            y17 = 2'd1;
        end
        else
        begin
            y17 = 2'd0;
        end
        yc17  = 11'(11'(y17) * 11'(D_1Y));
        idx18 = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (ry17_reg >= month_start(4'(i)))
            begin
                idx18 = 4'(i);
            end
        end
        dm18 = ry17_reg - month_start(idx18) + 9'd1;
        yr18 = 18'(18'(qc17_reg) * 18'(400)) + 18'(18'(c17_reg) * 18'(100))
             + {11'd0, q17_reg, 2'b00} + 18'(y17_reg) + 18'(YEAR_BASE)
             + 18'(idx18 >= 4'd10);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg     <= t1_next;
            oor_reg[1] <= sum1[41] != sum1[40];
            for (int i = 2; i <= STAGES; i++)
            begin
                oor_reg[i] <= oor_reg[i-1];
            end

            bh2_reg <= ap2[41:24];
            bl2_reg <= ap2[23:7];
            lo2_reg <= ap2[6:0];

            q1e3_reg <= p3[26:18];
            bh3_reg  <= bh2_reg;
            bl3_reg  <= bl2_reg;
            lo3_reg  <= lo2_reg;

            r1w4_reg <= d4[10:0];
            q1e4_reg <= q1e3_reg;
            bl4_reg  <= bl3_reg;
            lo4_reg  <= lo3_reg;

            if (r1w4_reg >= 11'(D_675))
            begin
                r1_5_reg <= 10'(r1w4_reg - 11'(D_675));
                q1_5_reg <= q1e4_reg + 9'd1;
            end
            else
            begin
                r1_5_reg <= r1w4_reg[9:0];
                q1_5_reg <= q1e4_reg;
            end
            bl5_reg <= bl4_reg;
            lo5_reg <= lo4_reg;

            x6_reg   <= x6;
            q2e6_reg <= p6[43:27];
            q1_6_reg <= q1_5_reg;
            lo6_reg  <= lo5_reg;

            r2w7_reg <= d7[10:0];
            q2e7_reg <= q2e6_reg;
            q1_7_reg <= q1_6_reg;
            lo7_reg  <= lo6_reg;

            days8_reg <= {q1_7_reg, q2_8};
            sod8_reg  <= {r2_8, lo7_reg};

            dd9_reg  <= dd9[24:0];
            he9_reg  <= ph9[21:17];
            sod9_reg <= sod8_reg;

            qce10_reg <= pc10[32:25];
            dd10_reg  <= dd9_reg;
            hrw10_reg <= dh10[12:0];
            he10_reg  <= he9_reg;

            rdw11_reg  <= dc11[18:0];
            qce11_reg  <= qce10_reg;
            hour11_reg <= he10_reg + 5'(ge11);
            hrem11_reg <= ge11 ? 12'(hrw10_reg - 13'(D_HOUR)) : hrw10_reg[11:0];

            rd12_reg   <= ge12 ? 18'(rdw11_reg - 19'(D_400Y)) : rdw11_reg[17:0];
            qc12_reg   <= qce11_reg + 8'(ge12);
            me12_reg   <= pm12[17:12];
            hrem12_reg <= hrem11_reg;
            hour12_reg <= hour11_reg;

            c13_reg    <= c13;
            rdc13_reg  <= 16'(rd12_reg - cc13);
            qc13_reg   <= qc12_reg;
            sw13_reg   <= ds13[6:0];
            me13_reg   <= me12_reg;
            hour13_reg <= hour12_reg;

            qe14_reg         <= pq14[28:24];
            rdc14_reg        <= rdc13_reg;
            c14_reg          <= c13_reg;
            qc14_reg         <= qc13_reg;
            tod14_reg.hour   <= hour13_reg;
            tod14_reg.minute <= me13_reg + 6'(ge14);
            tod14_reg.second <= ge14 ? 6'(sw13_reg - 7'(D_MIN)) : sw13_reg[5:0];

            r4w15_reg <= d15[11:0];
            qe15_reg  <= qe14_reg;
            c15_reg   <= c14_reg;
            qc15_reg  <= qc14_reg;
            tod15_reg <= tod14_reg;

            q16_reg   <= qe15_reg + 5'(ge16);
            r16_reg   <= ge16 ? 11'(r4w15_reg - 12'(D_4Y)) : r4w15_reg[10:0];
            c16_reg   <= c15_reg;
            qc16_reg  <= qc15_reg;
            tod16_reg <= tod15_reg;

            y17_reg   <= y17;
            ry17_reg  <= 9'(r16_reg - yc17);
            q17_reg   <= q16_reg;
            c17_reg   <= c16_reg;
            qc17_reg  <= qc16_reg;
            tod17_reg <= tod16_reg;

            year_reg  <= yr18[YEAR_W-1:0];
            month_reg <= (idx18 < 4'd10) ? idx18 + 4'd3 : idx18 - 4'd9;
            day_reg   <= dm18[4:0];
            tod18_reg <= tod17_reg;
        end
    end

    assign m_axis_tvalid = v_reg[STAGES-1];
    assign m_axis_tuser  = oor_reg[STAGES];
    assign m_axis_tdata  = {5'd0, tod18_reg.second, tod18_reg.minute, tod18_reg.hour,
                            day_reg, month_reg, year_reg};

endmodule

### rtl/ecd_checker.sv
// ----------------------------------------------------------------------------
// ecd_checker
// Port-level checks for the epoch seconds to civil date pipeline.
// ----------------------------------------------------------------------------
module ecd_checker
    import ecd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    tod_t tod;

    assign tod = {m_axis_tdata[30:26], m_axis_tdata[36:31], m_axis_tdata[42:37]};

    // held output beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // input side only stalls while the output beat is held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_date: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[20:17] >= 4'd1 && m_axis_tdata[20:17] <= 4'd12
            && m_axis_tdata[25:21] != 5'd0)
        else $error("month or day out of range");

    a_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> tod.hour < 5'd24 && tod.minute < 6'd60 && tod.second < 6'd60
            && m_axis_tdata[47:43] == 5'd0)
        else $error("time of day out of range");

endmodule

bind epoch_seconds_to_civil_date ecd_checker u_ecd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
